### src/iptp_pkg.sv
// Shared types and constants for the IP address text parser.
// Holds the parse state record, phase codes, status codes and character codes.
// No dependencies.
`timescale 1ns / 1ps

package iptp_pkg;

    // Parse phase, one-hot.
    typedef enum logic [3:0] {
        PH_START       = 4'b0001,
        PH_GROUP_START = 4'b0010,
        PH_IN_GROUP    = 4'b0100,
        PH_LEAD_COLON  = 4'b1000
    } phase_t;

    // Family codes.
    localparam logic [1:0] FAM_IPV4 = 2'd0;
    localparam logic [1:0] FAM_IPV6 = 2'd1;

    // Result status codes.
    localparam logic [1:0] ST_PARSED      = 2'd0;
    localparam logic [1:0] ST_MALFORMED   = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Marks a group that holds a hex letter and so cannot be a dotted part.
    localparam logic [9:0] NOT_DECIMAL = 10'd1023;
    localparam logic [9:0] OCTET_MAX   = 10'd255;

    typedef struct packed {
        logic [7:0][15:0] groups;
        logic [3:0]       group_count;
        logic [15:0]      hex_acc;
        logic [9:0]       dec_acc;
        logic [2:0]       digit_count;
        logic             first_zero;
        logic [3:0]       compress_pos;
        logic             compress_seen;
        logic [3:0][7:0]  octets;
        logic [2:0]       octet_count;
        logic             in_dotted;
        logic             failed;
        phase_t           phase;
        logic [1:0]       family;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        groups:        '0,
        group_count:   4'd0,
        hex_acc:       16'd0,
        dec_acc:       10'd0,
        digit_count:   3'd0,
        first_zero:    1'b0,
        compress_pos:  4'd0,
        compress_seen: 1'b0,
        octets:        '0,
        octet_count:   3'd0,
        in_dotted:     1'b0,
        failed:        1'b0,
        phase:         PH_START,
        family:        2'd0
    };

    // A decimal part is one to three digits, no leading zero, at most 255.
    function automatic logic part_ok(input parse_state_t s);
        part_ok = (s.digit_count != 3'd0) && (s.digit_count <= 3'd3) &&
                  !((s.digit_count > 3'd1) && s.first_zero) &&
                  (s.dec_acc <= OCTET_MAX);
    endfunction

endpackage

### src/iptp_finish.sv
// Result assembly for the IP address text parser: final checks, expansion of
// the compressed group run and packing of the address words.
// Depends on iptp_pkg.
`timescale 1ns / 1ps

module iptp_finish (
    input  iptp_pkg::parse_state_t st,
    output logic [1:0]             status,
    output logic [63:0]            address_high,
    output logic [63:0]            address_low
);
    import iptp_pkg::*;

    logic [7:0][15:0] grp;
    logic [3:0][7:0]  oct;
    logic [15:0]      r [8];
    logic             v6_ok;
    logic             v4_ok;
    logic [2:0]       last;
    logic [2:0]       gap;
    logic [2:0]       brk;
    logic [3:0]       brk_end;
    logic [31:0]      oct_word;

    always_comb begin
        grp    = st.groups;
        oct    = st.octets;
        v6_ok  = 1'b0;
        v4_ok  = 1'b0;
        last   = 3'd0;
        status = ST_MALFORMED;

        priority if (st.family > FAM_IPV6) begin
            status = ST_UNSUPPORTED;
        end else if (st.failed) begin
            status = ST_MALFORMED;
        end else if (st.in_dotted) begin
            if (part_ok(st) && st.octet_count == 3'd3) begin
                oct[3] = st.dec_acc[7:0];
                if (st.family == FAM_IPV4) begin
                    v4_ok = 1'b1;
                end else begin
                    v6_ok = 1'b1;
                    last  = st.group_count[2:0];
                end
            end
        end else if (st.phase == PH_GROUP_START) begin
            if (st.compress_seen && st.group_count == st.compress_pos + 4'd1) begin
                v6_ok = 1'b1;
                last  = st.compress_pos[2:0];
            end
        end else if (st.phase == PH_IN_GROUP) begin
            if (st.compress_seen || st.group_count == 4'd7) begin
                grp[st.group_count[2:0]] = st.hex_acc;
                v6_ok = 1'b1;
                last  = st.group_count[2:0];
            end
        end else begin
            status = ST_MALFORMED;
        end

        if (v4_ok || v6_ok) begin
            status = ST_PARSED;
        end
    end

    // Spread the groups after the compression point to the end of the address.
    always_comb begin
        brk     = st.compress_pos[2:0];
        gap     = st.compress_seen ? 3'd7 - last : 3'd0;
        brk_end = {1'b0, brk} + {1'b0, gap};
        for (int k = 0; k < 8; k++) begin
            if (!st.compress_seen || 4'(k) < {1'b0, brk}) begin
                r[k] = grp[3'(k)];
            end else if (4'(k) < brk_end) begin
                r[k] = 16'd0;
            end else begin
                r[k] = grp[3'(k) - gap];
            end
        end
    end

    assign oct_word = {oct[0], oct[1], oct[2], oct[3]};

    always_comb begin
        address_high = 64'd0;
        address_low  = 64'd0;
        if (v4_ok) begin
            address_low = {32'd0, oct_word};
        end else if (v6_ok) begin
            address_high = {r[0], r[1], r[2], r[3]};
            address_low  = st.in_dotted ? {r[4], r[5], oct_word} : {r[4], r[5], r[6], r[7]};
        end
    end

endmodule

### src/ip_address_text_parser_top.sv
// Top level of the IP address text parser: handshake registers, per-character
// state update and the result register.
// Depends on iptp_pkg and iptp_finish.
`timescale 1ns / 1ps

// The parser takes an address string one character per input beat, with the
// address family on the same beat (sampled on the first character), and
// gives one result beat when the string's zero character arrives. A result
// holds a status (parsed, malformed, unsupported family) and the 128-bit
// address: IPv6 in big-endian order over the high and low words, IPv4 in
// bits 31..0 of the low word, and zero on any failure. The block accepts one
// character in every clock cycle while it is not stalled. Each character
// passes through an input register and then through the state update into
// the state and result registers, so a result is registered as its
// terminating character leaves the input register. The only stall comes from
// the result side: a terminating character waits in the input register while
// an earlier result has not been taken, and characters behind it wait with
// it. All parse state returns to its reset value after every result, ready
// for the next string.

module ip_address_text_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_family,
    input  logic [7:0]  s_character,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_address_high,
    output logic [63:0] m_address_low
);
    import iptp_pkg::*;

    // Input register.
    logic        in_valid_reg;
    logic [1:0]  in_family_reg;
    logic [7:0]  in_char_reg;

    // Parse state.
    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t st_e;

    // Result register.
    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [63:0] m_high_reg;
    logic [63:0] m_low_reg;

    logic        advance;
    logic        result_now;
    logic [1:0]  fin_status;
    logic [63:0] fin_high;
    logic [63:0] fin_low;

    // Character classification.
    logic        c_is_dec;
    logic        c_is_hex;
    logic [7:0]  c_lower;
    logic [7:0]  c_letter_off;
    logic [3:0]  c_dec_val;
    logic [3:0]  c_hex_val;
    logic [13:0] dec_x10;
    logic [9:0]  dec_grow;

    // A character that causes no result never needs the output side, so it
    // moves on even while a result is still waiting.
    assign advance = in_valid_reg && ((in_char_reg != CH_END) || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_family_reg <= s_family;
            in_char_reg   <= s_character;
        end
    end

    assign c_is_dec     = (in_char_reg >= CH_ZERO) && (in_char_reg <= CH_NINE);
    assign c_lower      = in_char_reg | 8'h20;
    assign c_is_hex     = c_is_dec || ((c_lower >= 8'h61) && (c_lower <= 8'h66));
    assign c_letter_off = c_lower - 8'h57;
    assign c_dec_val    = in_char_reg[3:0];
    assign c_hex_val    = c_is_dec ? in_char_reg[3:0] : c_letter_off[3:0];
    assign dec_x10      = 14'(st_e.dec_acc) * 14'd10;
    assign dec_grow     = 10'(dec_x10 + 14'(c_dec_val));

    function automatic parse_state_t clear_part(input parse_state_t s);
        parse_state_t t;
        t             = s;
        t.hex_acc     = 16'd0;
        t.dec_acc     = 10'd0;
        t.digit_count = 3'd0;
        t.first_zero  = 1'b0;
        return t;
    endfunction

    // Start of a "::" run: one zero group marks the compression point.
    function automatic parse_state_t do_compress(input parse_state_t s);
        parse_state_t t;
        t                         = s;
        t.compress_seen           = 1'b1;
        t.compress_pos            = s.group_count;
        t.groups[s.group_count[2:0]] = 16'd0;
        t.group_count             = s.group_count + 4'd1;
        t.phase                   = PH_GROUP_START;
        return t;
    endfunction

    // The first character of a string fixes the family and the starting mode.
    always_comb begin
        st_e = state_reg;
        if (state_reg.phase == PH_START) begin
            st_e.family    = in_family_reg;
            st_e.phase     = PH_GROUP_START;
            st_e.in_dotted = (in_family_reg == FAM_IPV4);
        end
    end

    iptp_finish u_finish (
        .st           (st_e),
        .status       (fin_status),
        .address_high (fin_high),
        .address_low  (fin_low)
    );

    always_comb begin
        state_next = st_e;
        result_now = 1'b0;
        priority if (state_reg.phase == PH_START && in_family_reg == FAM_IPV6 &&
                     in_char_reg == CH_COLON) begin
            state_next.phase = PH_LEAD_COLON;
        end else if (in_char_reg == CH_END) begin
            result_now = 1'b1;
            state_next = STATE_RESET;
        end else if (st_e.failed || st_e.family > FAM_IPV6) begin
            state_next = st_e;
        end else if (st_e.in_dotted) begin
            // Dotted decimal part, IPv4 text or the tail of IPv6 text.
            priority if (c_is_dec) begin
                if (st_e.digit_count >= 3'd3) begin
                    state_next.failed = 1'b1;
                end else begin
                    if (st_e.digit_count == 3'd0) begin
                        state_next.first_zero = (in_char_reg == CH_ZERO);
                    end
                    state_next.dec_acc     = dec_grow;
                    state_next.digit_count = st_e.digit_count + 3'd1;
                end
            end else if (in_char_reg == CH_DOT) begin
                if (!part_ok(st_e) || st_e.octet_count >= 3'd3) begin
                    state_next.failed = 1'b1;
                end else begin
                    state_next = clear_part(st_e);
                    state_next.octets[st_e.octet_count[1:0]] = st_e.dec_acc[7:0];
                    state_next.octet_count = st_e.octet_count + 3'd1;
                end
            end else begin
                state_next.failed = 1'b1;
            end
        end else begin
            unique case (st_e.phase)
                PH_LEAD_COLON: begin
                    if (in_char_reg == CH_COLON) begin
                        state_next = do_compress(st_e);
                    end else begin
                        state_next.failed = 1'b1;
                    end
                end
                PH_IN_GROUP: begin
                    priority if (c_is_hex) begin
                        if (st_e.digit_count >= 3'd4) begin
                            state_next.failed = 1'b1;
                        end else begin
                            state_next.hex_acc = {st_e.hex_acc[11:0], c_hex_val};
                            if (!c_is_dec || st_e.dec_acc == NOT_DECIMAL) begin
                                state_next.dec_acc = NOT_DECIMAL;
                            end else if (st_e.digit_count < 3'd3) begin
                                state_next.dec_acc = dec_grow;
                            end
                            state_next.digit_count = st_e.digit_count + 3'd1;
                        end
                    end else if (in_char_reg == CH_COLON) begin
                        if (st_e.group_count >= 4'd7) begin
                            state_next.failed = 1'b1;
                        end else begin
                            state_next = clear_part(st_e);
                            state_next.groups[st_e.group_count[2:0]] = st_e.hex_acc;
                            state_next.group_count = st_e.group_count + 4'd1;
                            state_next.phase       = PH_GROUP_START;
                        end
                    end else if (in_char_reg == CH_DOT) begin
                        // Switch to an embedded dotted part after six groups
                        // or after a compression.
                        if (st_e.group_count >= 4'd7 ||
                            (st_e.group_count < 4'd6 && !st_e.compress_seen) ||
                            !part_ok(st_e)) begin
                            state_next.failed = 1'b1;
                        end else begin
                            state_next = clear_part(st_e);
                            state_next.group_count = st_e.group_count + 4'd1;
                            state_next.octets[0]   = st_e.dec_acc[7:0];
                            state_next.octet_count = 3'd1;
                            state_next.in_dotted   = 1'b1;
                        end
                    end else begin
                        state_next.failed = 1'b1;
                    end
                end
                PH_GROUP_START: begin
                    if (in_char_reg == CH_COLON && !st_e.compress_seen) begin
                        state_next = do_compress(st_e);
                    end else if (st_e.group_count >= 4'd8 || !c_is_hex) begin
                        state_next.failed = 1'b1;
                    end else begin
                        state_next.hex_acc     = 16'(c_hex_val);
                        state_next.dec_acc     = c_is_dec ? 10'(c_dec_val) : NOT_DECIMAL;
                        state_next.first_zero  = (in_char_reg == CH_ZERO);
                        state_next.digit_count = 3'd1;
                        state_next.phase       = PH_IN_GROUP;
                    end
                end
                default: begin
                    state_next = st_e;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register: loaded by a terminating character, cleared when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && result_now) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result_now) begin
            m_status_reg <= fin_status;
            m_high_reg   <= fin_high;
            m_low_reg    <= fin_low;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_address_high = m_high_reg;
    assign m_address_low  = m_low_reg;

endmodule
